// ===== src/pse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// Types, constants, seed tables and the lfsr step for the poisson spike
// encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int PSE_PAIRS     = 32;
    localparam int PSE_MAX_PAIRS = 32;
    localparam int PSE_LFSR_W    = 16;
    localparam int PSE_VALUE_W   = 8;
    localparam int PSE_PAIR_W    = 5;
    localparam int PSE_RATIO_W   = 7;
    localparam int PSE_DRAW5_W   = 5;
    localparam int PSE_DRAW8_W   = 8;
    localparam int PSE_DATA_W    = 32;
    localparam int PSE_ADDR_W    = 3;

    localparam logic [PSE_LFSR_W-1:0] PSE_TAPS = 16'hB400;

    localparam logic [PSE_ADDR_W-1:0] PSE_ADDR_RATIO = 3'd0;

    typedef enum logic
    {
        CMD_ENCODE = 1'b0,
        CMD_RELOAD = 1'b1
    } pse_cmd_t;

    typedef logic [PSE_LFSR_W-1:0] pse_lfsr_t;

    localparam pse_lfsr_t GEN_SEED [PSE_MAX_PAIRS] = '{
        16'h0011, 16'h0031, 16'h0051, 16'h0071, 16'h0091, 16'h00B1, 16'h00D1, 16'h00F1,
        16'h0111, 16'h0131, 16'h0151, 16'h0171, 16'h0191, 16'h01B1, 16'h01D1, 16'h01F1,
        16'h0211, 16'h0231, 16'h0251, 16'h0271, 16'h0291, 16'h02B1, 16'h02D1, 16'h02F1,
        16'h0311, 16'h0331, 16'h0351, 16'h0371, 16'h0391, 16'h03B1, 16'h03D1, 16'h03F1
    };

    localparam pse_lfsr_t SCALE_SEED [PSE_MAX_PAIRS] = '{
        16'h000B, 16'h002B, 16'h004B, 16'h006B, 16'h008B, 16'h00AB, 16'h00CB, 16'h00EB,
        16'h030B, 16'h032B, 16'h034B, 16'h036B, 16'h038B, 16'h03AB, 16'h03CB, 16'h03EB,
        16'h060B, 16'h062B, 16'h064B, 16'h066B, 16'h068B, 16'h06AB, 16'h06CB, 16'h06EB,
        16'h930B, 16'h932B, 16'h934B, 16'h936B, 16'h938B, 16'h93AB, 16'h93CB, 16'h93EB
    };

    // galois step: shift right, xor taps when the old bit 0 was set
    function automatic pse_lfsr_t pse_lfsr_step(input pse_lfsr_t s);
        pse_lfsr_t shifted;
        shifted = s >> 1;
        if (s[0])
        begin
            shifted = shifted ^ PSE_TAPS;
        end
        return shifted;
    endfunction

endpackage
`default_nettype wire

// ===== src/pse_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pse_in_if
// Input channel of the spike encoder: one command or sample per item.
// ----------------------------------------------------------------------------
interface pse_in_if import pse_pkg::*;;

    logic                   valid;
    logic                   ready;
    pse_cmd_t               command;
    logic [PSE_VALUE_W-1:0] sample_value;
    logic                   last_in_vector;

    modport source
    (
        output valid,
        output command,
        output sample_value,
        output last_in_vector,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  command,
        input  sample_value,
        input  last_in_vector,
        output ready
    );

endinterface
`default_nettype wire

// ===== src/pse_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pse_out_if
// Output channel of the spike encoder: one spike bit and its pair per item.
// ----------------------------------------------------------------------------
interface pse_out_if import pse_pkg::*;;

    logic                  valid;
    logic                  ready;
    logic                  spike;
    logic [PSE_PAIR_W-1:0] pair_used;

    modport source
    (
        output valid,
        output spike,
        output pair_used,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  spike,
        input  pair_used,
        output ready
    );

endinterface
`default_nettype wire

// ===== src/poisson_spike_encoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poisson_spike_encoder_top
// Poisson spike encoder: per-position pairs of 16-bit galois lfsrs draw a
// 5-bit and an 8-bit number, compared against the activation and the
// suppress ratio to give one spike bit per sample item.
// latency: an input register, then the result register, lie between input acceptance and result valid
// throughput: 1 item per cycle while the output is not stalled; lfsr file read, compare and step in the same cycle
// reload items never wait on the output and produce no result
// reset: lfsrs load their seeds, pair index and suppress ratio clear to zero
// ----------------------------------------------------------------------------
module poisson_spike_encoder_top import pse_pkg::*;
#(
    parameter int PAIRS = PSE_PAIRS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PSE_ADDR_W-1:0] paddr,
    input  wire logic [PSE_DATA_W-1:0] pwdata,
    output logic      [PSE_DATA_W-1:0] prdata,
    output logic                       pready,
    pse_in_if.sink                     sample_in,
    pse_out_if.source                  spike_out
);

    localparam int IDX_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam logic [IDX_W-1:0] LAST_PAIR = IDX_W'(PAIRS - 1);

    logic [PSE_RATIO_W-1:0] ratio_reg;
    logic [PSE_RATIO_W-1:0] ratio_next;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    pse_cmd_t               in_cmd_reg;
    logic [PSE_VALUE_W-1:0] in_value_reg;
    logic                   in_last_reg;

    pse_lfsr_t              gen_reg   [PAIRS];
    pse_lfsr_t              gen_next  [PAIRS];
    pse_lfsr_t              scale_reg [PAIRS];
    pse_lfsr_t              scale_next[PAIRS];
    logic [IDX_W-1:0]       pair_reg;
    logic [IDX_W-1:0]       pair_next;

    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   res_spike_reg;
    logic                   res_spike_next;
    logic [PSE_PAIR_W-1:0]  res_pair_reg;
    logic [PSE_PAIR_W-1:0]  res_pair_next;

    pse_lfsr_t              gen_cur;
    pse_lfsr_t              scale_cur;
    logic [PSE_DRAW5_W-1:0] draw5;
    logic [PSE_DRAW8_W-1:0] draw8;
    logic                   advance;
    logic                   do_encode;
    logic                   do_reload;
    logic                   cfg_write;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PSE_ADDR_W-1:2] == 1'b0);

    always_comb
    begin
        ratio_next = ratio_reg;
        if (cfg_write)
        begin
            ratio_next = pwdata[PSE_RATIO_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PSE_ADDR_W-1:2] == PSE_ADDR_RATIO[PSE_ADDR_W-1:2])
        begin
            prdata = {{(PSE_DATA_W - PSE_RATIO_W){1'b0}}, ratio_reg};
        end
    end

    // stage control
    assign advance   = in_valid_reg
                       && ((in_cmd_reg == CMD_RELOAD) || !res_valid_reg || spike_out.ready);
    assign do_encode = advance && (in_cmd_reg == CMD_ENCODE);
    assign do_reload = advance && (in_cmd_reg == CMD_RELOAD);

    assign sample_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample_in.valid && sample_in.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // draw and compare
    assign gen_cur   = gen_reg[pair_reg];
    assign scale_cur = scale_reg[pair_reg];
    assign draw5     = gen_cur[14:10];
    assign draw8     = scale_cur[15:8];

    assign res_spike_next = ({{(PSE_VALUE_W - PSE_DRAW5_W){1'b0}}, draw5} <= in_value_reg)
                            && ({1'b0, ratio_reg} <= draw8);
    assign res_pair_next  = PSE_PAIR_W'(pair_reg);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (do_encode)
        begin
            res_valid_next = 1'b1;
        end
        else if (spike_out.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // pair index
    always_comb
    begin
        pair_next = pair_reg;
        if (do_reload)
        begin
            pair_next = '0;
        end
        else if (do_encode)
        begin
            if (in_last_reg || (pair_reg == LAST_PAIR))
            begin
                pair_next = '0;
            end
            else
            begin
                pair_next = pair_reg + IDX_W'(1);
            end
        end
    end

    // lfsr file
    always_comb
    begin
        for (int i = 0; i < PAIRS; i++)
        begin
            gen_next[i]   = gen_reg[i];
            scale_next[i] = scale_reg[i];
            if (do_reload)
            begin
                gen_next[i]   = GEN_SEED[i];
                scale_next[i] = SCALE_SEED[i];
            end
            else if (do_encode && (pair_reg == IDX_W'(i)))
            begin
                gen_next[i]   = pse_lfsr_step(gen_cur);
                scale_next[i] = pse_lfsr_step(scale_cur);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= '0;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pair_reg      <= '0;
            for (int i = 0; i < PAIRS; i++)
            begin
                gen_reg[i]   <= GEN_SEED[i];
                scale_reg[i] <= SCALE_SEED[i];
            end
        end
        else
        begin
            ratio_reg     <= ratio_next;
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            pair_reg      <= pair_next;
            for (int i = 0; i < PAIRS; i++)
            begin
                gen_reg[i]   <= gen_next[i];
                scale_reg[i] <= scale_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            in_cmd_reg   <= sample_in.command;
            in_value_reg <= sample_in.sample_value;
            in_last_reg  <= sample_in.last_in_vector;
        end
        if (do_encode)
        begin
            res_spike_reg <= res_spike_next;
            res_pair_reg  <= res_pair_next;
        end
    end

    assign spike_out.valid     = res_valid_reg;
    assign spike_out.spike     = res_spike_reg;
    assign spike_out.pair_used = res_pair_reg;

endmodule
`default_nettype wire
